@@ rtl/rpn_pkg.sv @@
// Package: shared constants, codes and types for the postfix evaluator.
package rpn_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int WORD_W      = 32;
    localparam int STEP_W      = 6;
    localparam int DIV_STEPS   = WORD_W;
    localparam int FACT_LIMIT  = 34;

    typedef enum logic [2:0] {
        OP_PUSH = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_FACT = 3'd5,
        OP_END  = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_NEG_FACT = 2'd1,
        ERR_DIV_ZERO = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP_R,
        ST_POP_L,
        ST_EXEC,
        ST_WAIT,
        ST_END_RD,
        ST_EMIT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        A_IDLE,
        A_DIV,
        A_DIV_FIN,
        A_FACT,
        A_DONE
    } alu_state_t;

    typedef struct packed {
        logic              start;
        op_t               op;
        logic [WORD_W-1:0] lhs;
        logic [WORD_W-1:0] rhs;
    } alu_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] result;
        err_t              err;
    } alu_rsp_t;

endpackage

@@ rtl/postfix_expression_evaluator.sv @@
// Top level: postfix token sequencer around the operand stack memory and arithmetic unit.
//
//  channel | handshake            | fields
//  --------+----------------------+------------------------------
//  in      | in_valid / in_stall  | op[2:0], operand_value[31:0]
//  out     | out_valid / out_stall| expr_result[31:0], status[1:0]
//
// Push and ignored tokens finish in the idle state; arithmetic tokens pop operands, then run
// in the unit (factorial does one multiply a cycle); end reads any top, then emits.
// The stack memory is read one operand per cycle through a registered read port.
// Reset empties the stack and clears the error; stack contents are left as they are.
// The output register frees the input while an earlier result waits to be taken.
module postfix_expression_evaluator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  op,
    input  logic signed [31:0] operand_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] expr_result,
    output logic [1:0]  status
);

    rpn_pkg::ctrl_state_t        state_reg, state_next;
    logic [rpn_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    rpn_pkg::err_t               err_reg, err_next;
    rpn_pkg::op_t                op_reg, op_next;
    logic                        hit_reg, hit_next;
    logic [rpn_pkg::WORD_W-1:0]  r_reg, r_next;
    logic [rpn_pkg::WORD_W-1:0]  l_reg, l_next;
    logic [rpn_pkg::WORD_W-1:0]  res_reg, res_next;
    logic                        out_valid_reg, out_valid_next;
    logic [rpn_pkg::WORD_W-1:0]  out_res_reg, out_res_next;
    rpn_pkg::err_t               out_status_reg, out_status_next;

    logic                        wr_en, rd_en;
    logic [rpn_pkg::PTR_W-1:0]   wr_addr, rd_addr;
    logic [rpn_pkg::WORD_W-1:0]  wr_data, rd_data;
    logic [rpn_pkg::CNT_W-1:0]   cnt_dec;
    logic                        accept, not_empty, not_full, out_free;
    logic                        is_arith;
    rpn_pkg::op_t                in_op;
    rpn_pkg::alu_req_t           alu_req;
    rpn_pkg::alu_rsp_t           alu_rsp;

    assign in_op     = rpn_pkg::op_t'(op);
    assign in_stall  = (state_reg != rpn_pkg::ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign not_empty = (cnt_reg != '0);
    assign not_full  = (cnt_reg < rpn_pkg::CNT_W'(rpn_pkg::STACK_DEPTH));
    assign cnt_dec   = cnt_reg - 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign is_arith  = (in_op == rpn_pkg::OP_ADD || in_op == rpn_pkg::OP_SUB ||
                        in_op == rpn_pkg::OP_MUL || in_op == rpn_pkg::OP_DIV ||
                        in_op == rpn_pkg::OP_FACT);

    rpn_stack_ram u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rpn_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    assign alu_req.start = (state_reg == rpn_pkg::ST_EXEC);
    assign alu_req.op    = op_reg;
    assign alu_req.lhs   = l_reg;
    assign alu_req.rhs   = r_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rpn_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_op == rpn_pkg::OP_END)
                    begin
                        if (err_reg == rpn_pkg::ERR_NONE && not_empty)
                            state_next = rpn_pkg::ST_END_RD;
                        else
                            state_next = rpn_pkg::ST_EMIT;
                    end
                    else if (err_reg == rpn_pkg::ERR_NONE &&
                             (in_op == rpn_pkg::OP_ADD || in_op == rpn_pkg::OP_SUB ||
                              in_op == rpn_pkg::OP_MUL || in_op == rpn_pkg::OP_DIV ||
                              in_op == rpn_pkg::OP_FACT))
                        state_next = rpn_pkg::ST_POP_R;
                end
            end
            rpn_pkg::ST_POP_R:
            begin
                if (op_reg == rpn_pkg::OP_FACT)
                    state_next = rpn_pkg::ST_EXEC;
                else
                    state_next = rpn_pkg::ST_POP_L;
            end
            rpn_pkg::ST_POP_L:  state_next = rpn_pkg::ST_EXEC;
            rpn_pkg::ST_EXEC:   state_next = rpn_pkg::ST_WAIT;
            rpn_pkg::ST_WAIT:
            begin
                if (alu_rsp.done)
                    state_next = rpn_pkg::ST_IDLE;
            end
            rpn_pkg::ST_END_RD: state_next = rpn_pkg::ST_EMIT;
            rpn_pkg::ST_EMIT:
            begin
                if (out_free)
                    state_next = rpn_pkg::ST_IDLE;
            end
            default:            state_next = rpn_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next        = cnt_reg;
        err_next        = err_reg;
        op_next         = op_reg;
        hit_next        = hit_reg;
        r_next          = r_reg;
        l_next          = l_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_res_next    = out_res_reg;
        out_status_next = out_status_reg;
        wr_en           = 1'b0;
        wr_addr         = cnt_reg[rpn_pkg::PTR_W-1:0];
        wr_data         = operand_value;
        rd_en           = 1'b0;
        rd_addr         = cnt_dec[rpn_pkg::PTR_W-1:0];
        unique case (state_reg)
            rpn_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op_next  = in_op;
                    res_next = '0;
                    if (in_op == rpn_pkg::OP_END)
                    begin
                        if (err_reg == rpn_pkg::ERR_NONE && not_empty)
                            rd_en = 1'b1;
                    end
                    else if (err_reg == rpn_pkg::ERR_NONE)
                    begin
                        if (in_op == rpn_pkg::OP_PUSH)
                        begin
                            if (not_full)
                            begin
                                wr_en    = 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        else if (is_arith)
                        begin
                            rd_en    = not_empty;
                            hit_next = not_empty;
                            if (not_empty)
                                cnt_next = cnt_dec;
                        end
                    end
                end
            end
            rpn_pkg::ST_POP_R:
            begin
                r_next = hit_reg ? rd_data : '0;
                l_next = '0;
                if (op_reg != rpn_pkg::OP_FACT)
                begin
                    rd_en    = not_empty;
                    hit_next = not_empty;
                    if (not_empty)
                        cnt_next = cnt_dec;
                end
            end
            rpn_pkg::ST_POP_L:
            begin
                l_next = hit_reg ? rd_data : '0;
            end
            rpn_pkg::ST_EXEC: ;
            rpn_pkg::ST_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    if (alu_rsp.err != rpn_pkg::ERR_NONE)
                    begin
                        err_next = alu_rsp.err;
                        cnt_next = '0;
                    end
                    else if (not_full)
                    begin
                        wr_en    = 1'b1;
                        wr_data  = alu_rsp.result;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            rpn_pkg::ST_END_RD:
            begin
                res_next = rd_data;
            end
            rpn_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_res_next    = res_reg;
                    out_status_next = err_reg;
                    cnt_next        = '0;
                    err_next        = rpn_pkg::ERR_NONE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rpn_pkg::ST_IDLE;
            cnt_reg       <= '0;
            err_reg       <= rpn_pkg::ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        hit_reg        <= hit_next;
        r_reg          <= r_next;
        l_reg          <= l_next;
        res_reg        <= res_next;
        out_res_reg    <= out_res_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid   = out_valid_reg;
    assign expr_result = out_res_reg;
    assign status      = out_status_reg;

endmodule

@@ rtl/rpn_stack_ram.sv @@
// Operand stack memory: one write port, one registered read port.
module rpn_stack_ram (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [rpn_pkg::PTR_W-1:0]    wr_addr,
    input  logic [rpn_pkg::WORD_W-1:0]   wr_data,
    input  logic                         rd_en,
    input  logic [rpn_pkg::PTR_W-1:0]    rd_addr,
    output logic [rpn_pkg::WORD_W-1:0]   rd_data
);

    logic [rpn_pkg::WORD_W-1:0] mem [rpn_pkg::STACK_DEPTH];
    logic [rpn_pkg::WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/rpn_alu.sv @@
// Arithmetic unit: registered add/sub/mul, bit-serial divide, iterative factorial.
module rpn_alu (
    input  logic              clk,
    input  logic              rst_n,
    input  rpn_pkg::alu_req_t req,
    output rpn_pkg::alu_rsp_t rsp
);

    rpn_pkg::alu_state_t           state_reg, state_next;
    logic [rpn_pkg::WORD_W-1:0]    acc_reg, acc_next;
    logic [rpn_pkg::WORD_W-1:0]    rem_reg, rem_next;
    logic [rpn_pkg::WORD_W-1:0]    den_reg, den_next;
    logic [rpn_pkg::STEP_W-1:0]    step_reg, step_next;
    logic [rpn_pkg::STEP_W-1:0]    lim_reg, lim_next;
    logic                          neg_reg, neg_next;
    rpn_pkg::err_t                 err_reg, err_next;
    logic [rpn_pkg::WORD_W:0]      shifted;
    logic [rpn_pkg::WORD_W:0]      diff;

    assign shifted = {rem_reg, acc_reg[rpn_pkg::WORD_W-1]};
    assign diff    = shifted - {1'b0, den_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rpn_pkg::A_IDLE:
            begin
                if (req.start)
                begin
                    if (req.op == rpn_pkg::OP_DIV && req.rhs != '0)
                        state_next = rpn_pkg::A_DIV;
                    else if (req.op == rpn_pkg::OP_FACT && !req.rhs[rpn_pkg::WORD_W-1]
                             && req.rhs < rpn_pkg::WORD_W'(rpn_pkg::FACT_LIMIT))
                        state_next = rpn_pkg::A_FACT;
                    else
                        state_next = rpn_pkg::A_DONE;
                end
            end
            rpn_pkg::A_DIV:
            begin
                if (step_reg == rpn_pkg::STEP_W'(rpn_pkg::DIV_STEPS - 1))
                    state_next = rpn_pkg::A_DIV_FIN;
            end
            rpn_pkg::A_DIV_FIN: state_next = rpn_pkg::A_DONE;
            rpn_pkg::A_FACT:
            begin
                if (step_reg > lim_reg)
                    state_next = rpn_pkg::A_DONE;
            end
            rpn_pkg::A_DONE:    state_next = rpn_pkg::A_IDLE;
            default:            state_next = rpn_pkg::A_IDLE;
        endcase
    end

    always_comb
    begin
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        step_next = step_reg;
        lim_next  = lim_reg;
        neg_next  = neg_reg;
        err_next  = err_reg;
        unique case (state_reg)
            rpn_pkg::A_IDLE:
            begin
                if (req.start)
                begin
                    err_next = rpn_pkg::ERR_NONE;
                    acc_next = '0;
                    unique case (req.op)
                        rpn_pkg::OP_ADD: acc_next = req.lhs + req.rhs;
                        rpn_pkg::OP_SUB: acc_next = req.lhs - req.rhs;
                        rpn_pkg::OP_MUL: acc_next = req.lhs * req.rhs;
                        rpn_pkg::OP_DIV:
                        begin
                            if (req.rhs == '0)
                                err_next = rpn_pkg::ERR_DIV_ZERO;
                            acc_next  = req.lhs[rpn_pkg::WORD_W-1] ? -req.lhs : req.lhs;
                            den_next  = req.rhs[rpn_pkg::WORD_W-1] ? -req.rhs : req.rhs;
                            rem_next  = '0;
                            step_next = '0;
                            neg_next  = req.lhs[rpn_pkg::WORD_W-1] ^ req.rhs[rpn_pkg::WORD_W-1];
                        end
                        rpn_pkg::OP_FACT:
                        begin
                            if (req.rhs[rpn_pkg::WORD_W-1])
                                err_next = rpn_pkg::ERR_NEG_FACT;
                            else if (req.rhs < rpn_pkg::WORD_W'(rpn_pkg::FACT_LIMIT))
                                acc_next = rpn_pkg::WORD_W'(1);
                            step_next = rpn_pkg::STEP_W'(2);
                            lim_next  = req.rhs[rpn_pkg::STEP_W-1:0];
                        end
                        default: acc_next = '0;
                    endcase
                end
            end
            rpn_pkg::A_DIV:
            begin
                if (!diff[rpn_pkg::WORD_W])
                begin
                    rem_next = diff[rpn_pkg::WORD_W-1:0];
                    acc_next = {acc_reg[rpn_pkg::WORD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted[rpn_pkg::WORD_W-1:0];
                    acc_next = {acc_reg[rpn_pkg::WORD_W-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
            end
            rpn_pkg::A_DIV_FIN:
            begin
                if (neg_reg)
                    acc_next = -acc_reg;
            end
            rpn_pkg::A_FACT:
            begin
                if (step_reg <= lim_reg)
                begin
                    acc_next  = acc_reg * rpn_pkg::WORD_W'(step_reg);
                    step_next = step_reg + 1'b1;
                end
            end
            rpn_pkg::A_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rpn_pkg::A_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        step_reg <= step_next;
        lim_reg  <= lim_next;
        neg_reg  <= neg_next;
        err_reg  <= err_next;
    end

    assign rsp.done   = (state_reg == rpn_pkg::A_DONE);
    assign rsp.result = acc_reg;
    assign rsp.err    = err_reg;

endmodule
